>>> rtl/gsp3_pkg.sv
// Shared types and constants for the 3D Gauss-Seidel smoother.
`default_nettype none
package gsp3_pkg;
   localparam int KIND_BITS = 2;
   localparam int POS_BITS  = 5;
   localparam int DATA_BITS = 32;
   localparam int CSR_IDX_BITS = 3;
   localparam int MAX_DIM    = 32;
   localparam int VALUE_BITS = 32;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_WRITE = 2'd0,
      KIND_RUN   = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE_X = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE_Y = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE_Z = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SWEEPS = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE  = 3'd4;
endpackage
`default_nettype wire

>>> rtl/gsp3_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface gsp3_req_if;
   import gsp3_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] kind;
   logic [POS_BITS-1:0]  pos_x;
   logic [POS_BITS-1:0]  pos_y;
   logic [POS_BITS-1:0]  pos_z;
   logic signed [DATA_BITS-1:0] point_value;
   logic signed [DATA_BITS-1:0] source_value;
   modport source (output valid, kind, pos_x, pos_y, pos_z, point_value, source_value,
                   input ready);
   modport sink (input valid, kind, pos_x, pos_y, pos_z, point_value, source_value,
                 output ready);
endinterface

interface gsp3_rsp_if;
   import gsp3_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] done_kind;
   logic signed [DATA_BITS-1:0] read_value;
   modport source (output valid, done_kind, read_value, input ready);
   modport sink (input valid, done_kind, read_value, output ready);
endinterface
`default_nettype wire

>>> rtl/gsp3_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module gsp3_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

>>> rtl/gauss_seidel_poisson_smoother_3d_core.sv
// Top level: 3D Gauss-Seidel Poisson smoother with a shared accumulate unit.
// Writes go to S_RESP, reads via S_RD; a new request is taken once the response is raised.
// A run visits each interior point in turn: seven RAM reads, multiply, divide by six,
// write back, advance, over all sweeps; an empty run goes straight to the response.
// A response still waiting on rsp.ready holds the following one in place.
// Sync active-high reset: control and scale cleared, sizes 32, sweeps 1; grid is not reset.
`default_nettype none
module gauss_seidel_poisson_smoother_3d_core
   import gsp3_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   gsp3_req_if.sink   req,
   gsp3_rsp_if.source rsp,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [DATA_BITS-1:0]    csr_wdata
);
   localparam int AB = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CB = AB + 1;
   localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int GB = 3 * AB;
   localparam int SB = VALUE_BITS + 3;
   localparam int PB = 2 * VALUE_BITS;
   localparam int UB = PB - 14;
   localparam int NB = SB - 1;
   localparam int LOB = 18;
   localparam int HIB = NB - LOB;
   localparam logic signed [UB-1:0] VHI =
      {{(UB-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [UB-1:0] VLO =
      {{(UB-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};
   // 3 * 2^31 lifts the halved sum to a non-negative value
   localparam logic signed [SB-1:0] DIV_OFS = SB'(64'sd6442450944);
   localparam logic signed [UB-1:0] DIV_BIAS = UB'(64'sd2147483648);
   localparam logic [16:0] THIRD_HI = 17'd87381;   // (2^18 - 1) / 3
   localparam logic [18:0] THIRD_LO = 19'd349526;  // ceil(2^20 / 3)

   typedef enum logic [3:0] {
      S_IDLE, S_ACC, S_RHS, S_MUL, S_DIV, S_SUM, S_WB, S_NEXT, S_RD, S_RESP
   } state_type;

   state_type state_ff;
   logic [5:0] size_x_ff, size_y_ff, size_z_ff;
   logic [7:0] sweeps_ff, sweep_left_ff;
   logic signed [DATA_BITS-1:0] scale_ff;
   logic [AB-1:0] x_ff, y_ff, z_ff;
   logic [2:0] tap_ff;
   logic signed [SB-1:0] sum_ff;
   logic signed [PB-1:0] prod_ff;
   logic signed [UB-1:0] t1_ff, t2_ff;
   logic [HIB-1:0] div_hi_ff;
   logic [LOB:0] div_mid_ff;
   logic [NB-1:0] div_q_ff;
   logic [KIND_BITS-1:0] kind_ff;
   logic [DATA_BITS-1:0] rv_ff;
   logic rsp_valid_ff;
   logic [KIND_BITS-1:0] rsp_kind_ff;
   logic [DATA_BITS-1:0] rsp_value_ff;

   logic [CB-1:0] nx, ny, nz;
   logic [GB-1:0] addr;
   logic sol_we, src_we;
   logic [VALUE_BITS-1:0] sol_wd, sol_rd, src_wd, src_rd;
   logic [AB-1:0] ax, ay, az;
   logic signed [UB-1:0] upd;
   logic signed [SB-1:0] div_n, div_h, div_u;
   logic [LOB:0] div_part;
   logic [HIB+16:0] div_hi_prod;
   logic [LOB+19:0] div_lo_prod;
   logic has_int;

   function automatic logic [CB-1:0] eff(input logic [5:0] s);
      logic [CB:0] w;
      w = (CB+1)'(s);
      if (w > (CB+1)'(MAX_DIM)) w = (CB+1)'(MAX_DIM);
      return w[CB-1:0];
   endfunction

   assign nx = eff(size_x_ff);
   assign ny = eff(size_y_ff);
   assign nz = eff(size_z_ff);
   assign has_int = (nx >= CB'(3)) && (ny >= CB'(3)) && (nz >= CB'(3));

   // neighbor address for current tap; request position while idle
   always_comb begin
      ax = x_ff; ay = y_ff; az = z_ff;
      case (tap_ff)
         3'd0: ax = x_ff + AB'(1);
         3'd1: ax = x_ff - AB'(1);
         3'd2: ay = y_ff + AB'(1);
         3'd3: ay = y_ff - AB'(1);
         3'd4: az = z_ff + AB'(1);
         3'd5: az = z_ff - AB'(1);
         default: ;
      endcase
      if (state_ff == S_IDLE) begin
         ax = req.pos_x[AB-1:0]; ay = req.pos_y[AB-1:0]; az = req.pos_z[AB-1:0];
      end
   end
   assign addr = {ax, ay, az};

   // floor((sum+3)/6) = floor(floor((sum+3)/2)/3); split the lifted value at bit 18,
   // where 2^18 = 3*87381 + 1, so only the folded low part needs a reciprocal
   assign div_n = sum_ff + SB'(3);
   assign div_h = div_n >>> 1;
   assign div_u = div_h + DIV_OFS;
   assign div_part = (LOB+1)'(div_u[NB-1:LOB]) + (LOB+1)'(div_u[LOB-1:0]);
   assign div_hi_prod = (HIB+17)'(div_hi_ff) * (HIB+17)'(THIRD_HI);
   assign div_lo_prod = (LOB+20)'(div_mid_ff) * (LOB+20)'(THIRD_LO);

   always_comb begin
      upd = t1_ff + t2_ff;
      if (upd > VHI) upd = VHI;
      else if (upd < VLO) upd = VLO;
   end

   assign sol_we = (state_ff == S_IDLE && req.valid && req.kind == KIND_WRITE)
                 || state_ff == S_WB;
   assign src_we = state_ff == S_IDLE && req.valid && req.kind == KIND_WRITE;
   assign sol_wd = (state_ff == S_WB) ? upd[VALUE_BITS-1:0]
                                      : VALUE_BITS'(req.point_value);
   assign src_wd = VALUE_BITS'(req.source_value);

   gsp3_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_sol (
      .clock(clock), .wr_en(sol_we), .addr(addr), .wr_data(sol_wd), .rd_data(sol_rd));
   gsp3_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_src (
      .clock(clock), .wr_en(src_we), .addr(addr), .wr_data(src_wd), .rd_data(src_rd));

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.done_kind = rsp_kind_ff;
   assign rsp.read_value = rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_x_ff <= 6'd32; size_y_ff <= 6'd32; size_z_ff <= 6'd32;
         sweeps_ff <= 8'd1; scale_ff <= '0;
         rsp_valid_ff <= 1'b0;
         tap_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SIZE_X: size_x_ff <= csr_wdata[5:0];
               CSR_SIZE_Y: size_y_ff <= csr_wdata[5:0];
               CSR_SIZE_Z: size_z_ff <= csr_wdata[5:0];
               CSR_SWEEPS: sweeps_ff <= csr_wdata[7:0];
               CSR_SCALE:  scale_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  kind_ff <= req.kind;
                  rv_ff <= '0;
                  unique case (req.kind)
                     KIND_WRITE: state_ff <= S_RESP;
                     KIND_READ:  state_ff <= S_RD;
                     KIND_RUN: begin
                        x_ff <= AB'(1); y_ff <= AB'(1); z_ff <= AB'(1);
                        tap_ff <= '0; sum_ff <= '0;
                        sweep_left_ff <= sweeps_ff;
                        state_ff <= (has_int && sweeps_ff != 8'd0) ? S_ACC : S_RESP;
                     end
                     default: ;
                  endcase
               end
            end
            S_RD: begin
               // registered read of the accepted address is valid now
               rv_ff <= DATA_BITS'(sol_rd);
               state_ff <= S_RESP;
            end
            S_ACC: begin
               // data of tap-1 arrives now; tap 6 addresses the center
               if (tap_ff != 3'd0)
                  sum_ff <= sum_ff + SB'($signed(sol_rd));
               if (tap_ff == 3'd6) state_ff <= S_RHS;
               tap_ff <= tap_ff + 3'd1;
            end
            S_RHS: begin
               prod_ff <= PB'($signed(scale_ff)) * PB'($signed(src_rd));
               div_hi_ff <= div_u[NB-1:LOB];
               div_mid_ff <= div_part;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               t1_ff <= UB'((prod_ff + PB'(32768)) >>> 16);
               div_q_ff <= NB'(div_hi_prod) + NB'(div_lo_prod[LOB+19:20]);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               t2_ff <= $signed(UB'(div_q_ff)) - DIV_BIAS;
               tap_ff <= 3'd6;
               state_ff <= S_WB;
            end
            S_WB: state_ff <= S_NEXT;
            S_NEXT: begin
               tap_ff <= '0; sum_ff <= '0;
               state_ff <= S_ACC;
               if (CB'(z_ff) + CB'(2) < nz) z_ff <= z_ff + AB'(1);
               else begin
                  z_ff <= AB'(1);
                  if (CB'(y_ff) + CB'(2) < ny) y_ff <= y_ff + AB'(1);
                  else begin
                     y_ff <= AB'(1);
                     if (CB'(x_ff) + CB'(2) < nx) x_ff <= x_ff + AB'(1);
                     else begin
                        x_ff <= AB'(1);
                        sweep_left_ff <= sweep_left_ff - 8'd1;
                        if (sweep_left_ff == 8'd1) state_ff <= S_RESP;
                     end
                  end
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff <= kind_ff;
                  rsp_value_ff <= rv_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_resp_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("response not raised");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready)
      else $error("ready while busy");
   a_wb_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |-> $past(state_ff) == S_DIV)
      else $error("write back out of order");
endmodule
`default_nettype wire

>>> test/gsp3_scoreboard.sv
// Response checker for the 3D Gauss-Seidel smoother: own grid model and in-order compare.
`timescale 1ns / 1ps
module gsp3_scoreboard
   import gsp3_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   gsp3_req_if                     req,
   gsp3_rsp_if                     rsp,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [DATA_BITS-1:0]    csr_wdata,
   output int                      fault_count,
   output int                      open_count
);
   localparam int DIM = 32;

   typedef struct {
      kind_type                    kind;
      logic signed [DATA_BITS-1:0] value;
   } outcome_type;

   outcome_type                 pending_done[$];
   logic signed [DATA_BITS-1:0] grid_u [0:DIM*DIM*DIM-1];
   logic signed [DATA_BITS-1:0] grid_f [0:DIM*DIM*DIM-1];
   int                          dim_x, dim_y, dim_z, sweeps;
   logic signed [DATA_BITS-1:0] scale;
   int                          faults = 0;

   function automatic int cell_of(int x, int y, int z);
      return (x * DIM + y) * DIM + z;
   endfunction

   function automatic int clamp_dim(int s);
      return (s > DIM) ? DIM : s;
   endfunction

   function automatic logic signed [DATA_BITS-1:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[DATA_BITS-1:0];
   endfunction

   // Floor of n/6 with round-half-up bias.
   function automatic longint sixth_of(longint n);
      longint q;
      q = (n + 3) / 6;
      if (((n + 3) % 6) != 0 && (n + 3) < 0) q = q - 1;
      return q;
   endfunction

   task automatic relax_grid();
      int     nx, ny, nz, c;
      longint sum, prod;
      nx = clamp_dim(dim_x);
      ny = clamp_dim(dim_y);
      nz = clamp_dim(dim_z);
      for (int s = 0; s < sweeps; s++)
         for (int x = 1; x + 1 < nx; x++)
            for (int y = 1; y + 1 < ny; y++)
               for (int z = 1; z + 1 < nz; z++) begin
                  c = cell_of(x, y, z);
                  sum = longint'(grid_u[cell_of(x + 1, y, z)]) + grid_u[cell_of(x - 1, y, z)]
                      + grid_u[cell_of(x, y + 1, z)] + grid_u[cell_of(x, y - 1, z)]
                      + grid_u[cell_of(x, y, z + 1)] + grid_u[cell_of(x, y, z - 1)];
                  prod = longint'(scale) * longint'(grid_f[c]);
                  grid_u[c] = clip(((prod + 32768) >>> 16) + sixth_of(sum));
               end
   endtask

   always @(posedge clock) begin
      outcome_type exp_done;
      kind_type k;
      int       c;
      if (reset) begin
         pending_done.delete();
         dim_x = DIM;
         dim_y = DIM;
         dim_z = DIM;
         sweeps = 1;
         scale = '0;
      end else begin
         // compare before predicting: a response never belongs to the same-edge request
         if (rsp.valid && rsp.ready) begin
            if (pending_done.size() == 0) begin
               $display("%0t: unexpected response kind %0d value %h", $time,
                        rsp.done_kind, rsp.read_value);
               faults++;
            end else begin
               exp_done = pending_done.pop_front();
               if (rsp.done_kind !== exp_done.kind) begin
                  $display("%0t: done_kind expected %0d actual %0d", $time,
                           exp_done.kind, rsp.done_kind);
                  faults++;
               end
               if (rsp.read_value !== exp_done.value) begin
                  $display("%0t: read_value expected %h actual %h", $time,
                           exp_done.value, rsp.read_value);
                  faults++;
               end
            end
         end
         if (req.valid && req.ready) begin
            k = kind_type'(req.kind);
            c = cell_of(req.pos_x, req.pos_y, req.pos_z);
            exp_done.kind = k;
            exp_done.value = '0;
            case (k)
               KIND_WRITE: begin
                  grid_u[c] = req.point_value;
                  grid_f[c] = req.source_value;
               end
               KIND_RUN:  relax_grid();
               KIND_READ: exp_done.value = grid_u[c];
               default: ;
            endcase
            if (k != KIND_NONE) pending_done.push_back(exp_done);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SIZE_X: dim_x = csr_wdata[5:0];
               CSR_SIZE_Y: dim_y = csr_wdata[5:0];
               CSR_SIZE_Z: dim_z = csr_wdata[5:0];
               CSR_SWEEPS: sweeps = csr_wdata[7:0];
               CSR_SCALE:  scale = csr_wdata;
               default: ;
            endcase
         end
      end
      open_count <= pending_done.size();
      fault_count <= faults;
   end
endmodule

>>> test/tb_gauss_seidel_poisson_smoother_3d_core.sv
// Stimulus and verdict for the 3D Gauss-Seidel smoother core.
`timescale 1ns / 1ps
module tb_gauss_seidel_poisson_smoother_3d_core;
   import gsp3_pkg::*;

   localparam int IDLE_LIMIT = 40000;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [DATA_BITS-1:0]    csr_wdata;
   int                      fault_count, open_count;
   int                      idle_cycles = 0;
   int                      sent = 0;
   int                      settings = 0;
   int                      box_x, box_y, box_z;
   bit                      steady = 0;
   bit                      written [0:32767];
   int                      written_cells[$];

   gsp3_req_if req();
   gsp3_rsp_if rsp();

   gauss_seidel_poisson_smoother_3d_core u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   gsp3_scoreboard u_scoreboard (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fault_count(fault_count), .open_count(open_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 6))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3, 4: return $urandom;
         default: return 32'($urandom_range(0, 8 << 16)) - (32'd4 << 16);
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3: return $urandom;
         default: return -32'($urandom_range(0, 1 << 16));
      endcase
   endfunction

   function automatic int clamp_dim(int s);
      return (s > 32) ? 32 : s;
   endfunction

   task automatic send_item(kind_type k, int x, int y, int z, logic [31:0] pv,
                            logic [31:0] sv);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.kind <= k;
      req.pos_x <= x[4:0];
      req.pos_y <= y[4:0];
      req.pos_z <= z[4:0];
      req.point_value <= pv;
      req.source_value <= sv;
      do @(posedge clock); while (!req.ready);
      sent++;
      if (k == KIND_WRITE && !written[(x * 32 + y) * 32 + z]) begin
         written[(x * 32 + y) * 32 + z] = 1'b1;
         written_cells.push_back((x * 32 + y) * 32 + z);
      end
   endtask

   task automatic write_point(int x, int y, int z);
      send_item(KIND_WRITE, x, y, z, pick_value(), pick_value());
   endtask

   task automatic read_known();
      int c;
      c = written_cells[$urandom_range(0, written_cells.size() - 1)];
      send_item(KIND_READ, c >> 10, (c >> 5) & 31, c & 31, $urandom, $urandom);
   endtask

   // Hold off until every response is back, then let a trailing ignored item drain.
   task automatic settle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(int sx, int sy, int sz, int sw, logic [31:0] sc);
      settle();
      if ($urandom_range(0, 2) == 0)
         csr_write(CSR_SCALE + 3'($urandom_range(1, 3)), $urandom);
      csr_write(CSR_SIZE_X, 32'(sx));
      csr_write(CSR_SIZE_Y, 32'(sy));
      csr_write(CSR_SIZE_Z, 32'(sz));
      csr_write(CSR_SWEEPS, 32'(sw));
      csr_write(CSR_SCALE, sc);
      csr_we <= 1'b0;
      box_x = clamp_dim(sx);
      box_y = clamp_dim(sy);
      box_z = clamp_dim(sz);
      settings++;
   endtask

   // Runs read every point of the used box apart from its edges, so write all of it first.
   task automatic fill_box();
      for (int x = 0; x < box_x; x++)
         for (int y = 0; y < box_y; y++)
            for (int z = 0; z < box_z; z++)
               write_point(x, y, z);
   endtask

   task automatic mixed_traffic(int count);
      repeat (count) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7:
               if (box_x > 0 && box_y > 0 && box_z > 0)
                  write_point($urandom_range(0, box_x - 1), $urandom_range(0, box_y - 1),
                              $urandom_range(0, box_z - 1));
               else
                  write_point($urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 31));
            8: write_point($urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 31));
            9, 10, 11, 12, 13, 14: read_known();
            15, 16, 17: send_item(KIND_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
                                  $urandom_range(0, 31), $urandom, $urandom);
            default: send_item(KIND_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                               $urandom_range(0, 31), $urandom, $urandom);
         endcase
      end
   endtask

   // Response side: random stalls with occasional stretches of steady acceptance.
   initial begin
      int stall;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_gauss_seidel_poisson_smoother_3d_core: errors");
         $finish;
      end
   end

   initial begin
      int sx, sy, sz;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req.valid <= 1'b0;
      req.kind <= KIND_NONE;
      req.pos_x <= '0;
      req.pos_y <= '0;
      req.pos_z <= '0;
      req.point_value <= '0;
      req.source_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      box_x = 32;
      box_y = 32;
      box_z = 32;

      // directed: corner points, extreme values, ignored kind, no-op runs
      send_item(KIND_WRITE, 0, 0, 0, 32'h7fffffff, 32'h80000000);
      send_item(KIND_WRITE, 31, 31, 31, 32'h80000000, 32'h7fffffff);
      send_item(KIND_WRITE, 31, 0, 17, 32'hffffffff, 32'h00000001);
      send_item(KIND_WRITE, 0, 31, 5, 32'h00010000, 32'hffff0000);
      send_item(KIND_READ, 0, 0, 0, 32'hffffffff, 32'hffffffff);
      send_item(KIND_NONE, 31, 31, 31, 32'hffffffff, 32'hffffffff);
      send_item(KIND_READ, 31, 31, 31, 0, 0);
      send_item(KIND_READ, 31, 0, 17, 0, 0);
      send_item(KIND_READ, 0, 31, 5, 0, 0);
      configure(32, 32, 32, 0, 32'h7fffffff);
      send_item(KIND_RUN, 0, 0, 0, 0, 0);
      configure(2, 32, 32, 1, 32'h80000000);
      send_item(KIND_RUN, 31, 31, 31, 0, 0);
      configure(32, 1, 0, 3, 32'h0);
      send_item(KIND_RUN, 0, 0, 0, 0, 0);
      send_item(KIND_READ, 0, 0, 0, 0, 0);

      // most sweeps on the smallest grid
      configure(3, 3, 3, 255, 32'h80000000);
      fill_box();
      mixed_traffic(60);
      // oversized x register is treated as the full dimension
      configure(63, 3, 3, 2, 32'h7fffffff);
      fill_box();
      mixed_traffic(60);
      configure(0, 5, 5, 3, pick_scale());
      mixed_traffic(40);

      repeat (9) begin
         sx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
         sy = $urandom_range(3, 5);
         sz = $urandom_range(3, 5);
         configure(sx, sy, sz, $urandom_range(0, 4), pick_scale());
         steady = ($urandom_range(0, 3) == 0);
         fill_box();
         mixed_traffic(80);
         steady = 0;
      end

      settle();
      $display("sent %0d requests over %0d register settings: corner points, saturation,",
               sent, settings);
      $display("ignored kinds, empty and oversized grids, zero to 255 sweeps");
      if (fault_count == 0)
         $display("tb_gauss_seidel_poisson_smoother_3d_core: clean");
      else
         $display("tb_gauss_seidel_poisson_smoother_3d_core: errors");
      $finish;
   end
endmodule

>>> filelist.f
rtl/gsp3_pkg.sv
rtl/gsp3_if.sv
rtl/gsp3_ram.sv
rtl/gauss_seidel_poisson_smoother_3d_core.sv
test/gsp3_scoreboard.sv
test/tb_gauss_seidel_poisson_smoother_3d_core.sv
